/* design/sec_pkg.sv */
// ----------------------------------------------------------------------------
// sec_pkg
// Shared types and constants for the saturating event counter bank.
// ----------------------------------------------------------------------------
package sec_pkg;

  localparam int CNT_W_DEF    = 64;
  localparam int AMT_W        = 64;
  localparam int NUM_COUNTERS = 69;
  localparam int IDX_W        = 7;
  localparam int MAX_OPS      = 7;
  localparam int OPN_W        = 3;

  // item kinds
  localparam logic [2:0] K_GENERIC = 3'd0;
  localparam logic [2:0] K_NEG     = 3'd1;
  localparam logic [2:0] K_REQ     = 3'd2;
  localparam logic [2:0] K_START   = 3'd3;
  localparam logic [2:0] K_CLOSE   = 3'd4;
  localparam logic [2:0] K_READ    = 3'd5;

  // generic event codes
  localparam logic [3:0] EV_SESS_UP   = 4'd4;
  localparam logic [3:0] EV_SESS_DOWN = 4'd5;
  localparam logic [3:0] EV_LAST      = 4'd10;

  // negotiation
  localparam logic [2:0] NEG_SUCCESS = 3'd0;
  localparam logic [2:0] NEG_UNKNOWN = 3'd4;

  // request commands
  localparam logic [7:0] CMD_CONNECT = 8'd1;
  localparam logic [7:0] CMD_UDP     = 8'd3;

  // io status
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_BLOCK    = 4'd1;
  localparam logic [3:0] ST_TMPBLOCK = 4'd2;
  localparam logic [3:0] ST_TIMEOUT  = 4'd3;
  localparam logic [3:0] ST_IOERROR  = 4'd4;
  localparam logic [3:0] ST_ERROR    = 4'd5;
  localparam logic [3:0] ST_CLOSE    = 4'd6;
  localparam logic [3:0] ST_ADMIN    = 4'd7;

  localparam logic [1:0] PR_UNKNOWN = 2'd2;

  // counter layout
  localparam logic [6:0] IX_ACCEPTED = 7'd0;
  localparam logic [6:0] IX_NEGFAIL  = 7'd2;
  localparam logic [6:0] IX_REQFAIL  = 7'd3;
  localparam logic [6:0] IX_ESTAB    = 7'd4;
  localparam logic [6:0] IX_CLOSED   = 7'd5;
  localparam logic [6:0] IX_SESSERR  = 7'd6;
  localparam logic [6:0] IX_ACTIVE   = 7'd11;
  localparam logic [6:0] IX_NEG      = 7'd12;
  localparam logic [6:0] IX_REQ      = 7'd17;
  localparam logic [6:0] IX_SESS     = 7'd49;
  localparam logic [6:0] IX_CLOSE    = 7'd61;

  localparam logic [1:0] SK_STARTED = 2'd0;
  localparam logic [1:0] SK_ACTIVE  = 2'd1;
  localparam logic [1:0] SK_CLOSED  = 2'd2;
  localparam logic [1:0] SK_ERRORS  = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_READ = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [IDX_W-1:0] idx;
  } op_t;

  typedef op_t [MAX_OPS-1:0] op_list_t;

  typedef struct packed {
    op_list_t         ops;
    logic [OPN_W-1:0] n_ops;
  } plan_t;

endpackage

/* design/sec_opgen.sv */
// ----------------------------------------------------------------------------
// sec_opgen
// Decodes one input word into the ordered list of counter operations.
// ----------------------------------------------------------------------------
module sec_opgen import sec_pkg::*; (
  input  logic [2:0] kind,
  input  logic [3:0] event_code,
  input  logic [2:0] negotiation_code,
  input  logic [7:0] command_byte,
  input  logic [3:0] io_status,
  input  logic [1:0] protocol_code,
  input  logic [6:0] read_index,
  output plan_t      plan
);

  function automatic logic [2:0] status_class(input logic [3:0] s);
    logic [2:0] c;
    case (s)
      ST_OK:                 c = 3'd0;
      ST_BLOCK, ST_TMPBLOCK: c = 3'd1;
      ST_TIMEOUT:            c = 3'd2;
      ST_IOERROR:            c = 3'd3;
      ST_ERROR:              c = 3'd4;
      ST_CLOSE:              c = 3'd5;
      ST_ADMIN:              c = 3'd6;
      default:               c = 3'd7;
    endcase
    return c;
  endfunction

  function automatic op_t mk(input op_kind_t k, input logic [IDX_W-1:0] i);
    op_t o;
    o.kind = k;
    o.idx  = i;
    return o;
  endfunction

  logic [2:0]       neg_s;
  logic [1:0]       cmd_c;
  logic [2:0]       st_c;
  logic [1:0]       pr_s;
  logic [IDX_W-1:0] sb;
  logic             st_err;

  always_comb begin
    neg_s  = (negotiation_code > NEG_UNKNOWN) ? NEG_UNKNOWN : negotiation_code;
    cmd_c  = (command_byte >= CMD_CONNECT && command_byte <= CMD_UDP) ?
             2'(command_byte - CMD_CONNECT) : 2'd3;
    st_c   = status_class(io_status);
    pr_s   = (protocol_code > PR_UNKNOWN) ? PR_UNKNOWN : protocol_code;
    sb     = IX_SESS + {3'b000, pr_s, 2'b00};
    st_err = (io_status == ST_TIMEOUT) || (io_status == ST_IOERROR) ||
             (io_status == ST_ERROR);

    plan = '0;
    case (kind)
      K_GENERIC: begin
        if (event_code <= EV_LAST) begin
          plan.ops[0] = mk(OP_ADD, IX_ACCEPTED + {3'b000, event_code});
          plan.n_ops  = 3'd1;
          if (event_code == EV_SESS_UP) begin
            plan.ops[1] = mk(OP_ADD, IX_ACTIVE);
            plan.n_ops  = 3'd2;
          end else if (event_code == EV_SESS_DOWN) begin
            plan.ops[1] = mk(OP_SUB, IX_ACTIVE);
            plan.n_ops  = 3'd2;
          end
        end
      end
      K_NEG: begin
        plan.ops[0] = mk(OP_ADD, IX_NEG + {4'b0000, neg_s});
        plan.ops[1] = mk(OP_ADD, IX_NEGFAIL);
        plan.n_ops  = (neg_s != NEG_SUCCESS) ? 3'd2 : 3'd1;
      end
      K_REQ: begin
        plan.ops[0] = mk(OP_ADD, IX_REQ + {2'b00, cmd_c, st_c});
        plan.ops[1] = mk(OP_ADD, IX_REQFAIL);
        plan.n_ops  = (st_c != 3'd0) ? 3'd2 : 3'd1;
      end
      K_START: begin
        plan.ops[0] = mk(OP_ADD, IX_ESTAB);
        plan.ops[1] = mk(OP_ADD, IX_ACTIVE);
        plan.ops[2] = mk(OP_ADD, sb + {5'b00000, SK_STARTED});
        plan.ops[3] = mk(OP_ADD, sb + {5'b00000, SK_ACTIVE});
        plan.n_ops  = 3'd4;
      end
      K_CLOSE: begin
        plan.ops[0] = mk(OP_ADD, IX_CLOSED);
        plan.ops[1] = mk(OP_SUB, IX_ACTIVE);
        plan.ops[2] = mk(OP_ADD, sb + {5'b00000, SK_CLOSED});
        plan.ops[3] = mk(OP_SUB, sb + {5'b00000, SK_ACTIVE});
        plan.ops[4] = mk(OP_ADD, IX_CLOSE + {4'b0000, st_c});
        plan.ops[5] = mk(OP_ADD, IX_SESSERR);
        plan.ops[6] = mk(OP_ADD, sb + {5'b00000, SK_ERRORS});
        plan.n_ops  = st_err ? 3'd7 : 3'd5;
      end
      K_READ: begin
        if (read_index < IDX_W'(NUM_COUNTERS)) begin
          plan.ops[0] = mk(OP_READ, read_index);
          plan.n_ops  = 3'd1;
        end
      end
      default: plan = '0;
    endcase
  end

endmodule

/* design/sec_alu.sv */
// ----------------------------------------------------------------------------
// sec_alu
// Shared saturating add / floored subtract unit for one counter.
// ----------------------------------------------------------------------------
module sec_alu import sec_pkg::*; #(
  parameter int COUNTER_WIDTH = CNT_W_DEF
) (
  input  logic [COUNTER_WIDTH-1:0] cur,
  input  logic [AMT_W-1:0]         amount,
  input  logic                     sub,
  output logic [COUNTER_WIDTH-1:0] res
);

  logic [AMT_W-1:0] cur_x;
  logic [AMT_W:0]   sum;
  logic [AMT_W:0]   cmax;

  always_comb begin
    cur_x = AMT_W'(cur);
    sum   = {1'b0, cur_x} + {1'b0, amount};
    cmax  = (AMT_W + 1)'({COUNTER_WIDTH{1'b1}});
    if (sub) begin
      res = (amount >= cur_x) ? '0 : COUNTER_WIDTH'(cur_x - amount);
    end else begin
      res = (sum >= cmax) ? {COUNTER_WIDTH{1'b1}} : sum[COUNTER_WIDTH-1:0];
    end
  end

endmodule

/* design/saturating_event_counter_bank_core.sv */
// ----------------------------------------------------------------------------
// saturating_event_counter_bank_core
// Bank of 69 saturating statistics counters with event update and read.
// ----------------------------------------------------------------------------
// Each accepted word is decoded into a list of up to seven counter operations,
// which one shared add/subtract unit applies one at a time through the single
// port of the counter memory: each operation is a registered read, then a
// write. A word is accepted in the idle state and its result word is posted
// from the done state; a word that touches no counter goes straight from one
// to the other. The input stalls until the word is back in idle. The result
// word sits in an output register, so the next word is taken while it waits.
// Counters are zero after reset through per-entry valid bits; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module saturating_event_counter_bank_core import sec_pkg::*; #(
  parameter int COUNTER_WIDTH = CNT_W_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [3:0]  in_event_code,
  input  logic [2:0]  in_negotiation_code,
  input  logic [7:0]  in_command_byte,
  input  logic [3:0]  in_io_status,
  input  logic [1:0]  in_protocol_code,
  input  logic [63:0] in_amount,
  input  logic [6:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_read_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_WR   = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  plan_t                    plan, plan_r;
  logic [AMT_W-1:0]         amt_r;
  logic [OPN_W-1:0]         op_cnt_r, op_cnt_nxt;
  logic [AMT_W-1:0]         res_r;
  logic                     out_valid_r;
  logic [AMT_W-1:0]         out_data_r;

  logic [COUNTER_WIDTH-1:0] mem [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0]  vld_r;
  logic [COUNTER_WIDTH-1:0] rd_data_r;
  logic                     rd_vld_r;
  logic [COUNTER_WIDTH-1:0] cur;
  logic [COUNTER_WIDTH-1:0] alu_res;
  op_t                      cur_op;

  logic in_acc, out_load, last_op, do_wr;

  sec_opgen u_opgen (
    .kind             (in_kind),
    .event_code       (in_event_code),
    .negotiation_code (in_negotiation_code),
    .command_byte     (in_command_byte),
    .io_status        (in_io_status),
    .protocol_code    (in_protocol_code),
    .read_index       (in_read_index),
    .plan             (plan)
  );

  assign cur_op = plan_r.ops[op_cnt_r];
  // entries never written read as zero
  assign cur    = rd_vld_r ? rd_data_r : '0;

  sec_alu #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_alu (
    .cur    (cur),
    .amount (amt_r),
    .sub    (cur_op.kind == OP_SUB),
    .res    (alu_res)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign last_op  = (op_cnt_r == plan_r.n_ops - 3'd1);
  assign do_wr    = (state_r == S_WR) && (cur_op.kind != OP_READ);

  always_comb begin
    state_nxt  = state_r;
    op_cnt_nxt = op_cnt_r;
    case (state_r)
      S_IDLE: begin
        op_cnt_nxt = '0;
        if (in_acc) state_nxt = (plan.n_ops == '0) ? S_DONE : S_RD;
      end
      S_RD: state_nxt = S_WR;
      S_WR: begin
        if (last_op) begin
          state_nxt = S_DONE;
        end else begin
          op_cnt_nxt = op_cnt_r + 3'd1;
          state_nxt  = S_RD;
        end
      end
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r  <= state_nxt;
      op_cnt_r <= op_cnt_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (do_wr) vld_r[cur_op.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      plan_r <= plan;
      amt_r  <= in_amount;
      res_r  <= '0;
    end else if (state_r == S_WR && cur_op.kind == OP_READ) begin
      res_r <= AMT_W'(cur);
    end
    if (out_load) out_data_r <= res_r;
  end

  // counter memory: one port, registered read
  always_ff @(posedge clk) begin
    if (do_wr) mem[cur_op.idx] <= alu_res;
    rd_data_r <= mem[cur_op.idx];
    rd_vld_r  <= vld_r[cur_op.idx];
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |=> state_r == S_WR)
    else $error("read cycle not followed by write cycle");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    do_wr |-> cur_op.idx < IDX_W'(NUM_COUNTERS))
    else $error("counter write out of range");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_WR) |-> op_cnt_r < plan_r.n_ops)
    else $error("operation counter past end of list");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result word posted outside done state");

endmodule

/* tb/saturating_event_counter_bank_core_tb.sv */
// ----------------------------------------------------------------------------
// saturating_event_counter_bank_core_tb
// Self-checking bench for the statistics counter bank. A behavioral copy of
// the 69 counters is updated for every word that the core accepts. Each
// result word is then compared against the oldest predicted read value.
// Traffic is directed corner cases first, then session-shaped random
// sequences mixed with noise. A long output hold-off follows, and the run
// ends with a drain phase that has no idle cycles.
// ----------------------------------------------------------------------------
module saturating_event_counter_bank_core_tb;
  import sec_pkg::*;

  localparam logic [63:0] CNT_MAX = {64{1'b1}} >> (64 - CNT_W_DEF);

  // close-reason / request-result classes
  localparam int CL_NORMAL    = 0;
  localparam int CL_BLOCKED   = 1;
  localparam int CL_TIMEOUT   = 2;
  localparam int CL_NETERR    = 3;
  localparam int CL_INTERR    = 4;
  localparam int CL_PEERCLOSE = 5;
  localparam int CL_ADMIN     = 6;
  localparam int CL_OTHER     = 7;

  localparam int REQ_CLASSES      = 8;
  localparam int CMD_SLOT_UNKNOWN = 3;
  localparam int SESS_STRIDE      = 4;

  localparam logic [2:0] K_UNUSED_LO = 3'd6;
  localparam logic [2:0] K_UNUSED_HI = 3'd7;
  localparam logic [3:0] EV_CLIENT_RD = 4'd7;
  localparam logic [3:0] EV_CODE_TOP  = 4'd15;
  localparam logic [2:0] NEG_CODE_TOP = 3'd7;
  localparam logic [1:0] PR_TOP       = 2'd3;
  localparam logic [6:0] IDX_TOP      = 7'd127;

  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  event_code;
    logic [2:0]  negotiation_code;
    logic [7:0]  command_byte;
    logic [3:0]  io_status;
    logic [1:0]  protocol_code;
    logic [63:0] amount;
    logic [6:0]  read_index;
  } stats_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_kind;
  logic [3:0]  in_event_code;
  logic [2:0]  in_negotiation_code;
  logic [7:0]  in_command_byte;
  logic [3:0]  in_io_status;
  logic [1:0]  in_protocol_code;
  logic [63:0] in_amount;
  logic [6:0]  in_read_index;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_read_data;

  logic [63:0] bank_model [NUM_COUNTERS];
  logic [63:0] pending_read_data [$];
  int          fail_count = 0;
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;

  saturating_event_counter_bank_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_event_code       (in_event_code),
    .in_negotiation_code (in_negotiation_code),
    .in_command_byte     (in_command_byte),
    .in_io_status        (in_io_status),
    .in_protocol_code    (in_protocol_code),
    .in_amount           (in_amount),
    .in_read_index       (in_read_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------- counter bank prediction ----------------

  function automatic void bump(input int ix, input logic [63:0] v);
    logic [63:0] cur;
    cur = bank_model[ix] & CNT_MAX;
    if (v >= CNT_MAX - cur) bank_model[ix] = CNT_MAX;
    else bank_model[ix] = cur + v;
  endfunction

  function automatic void lower(input int ix, input logic [63:0] v);
    if (v >= bank_model[ix]) bank_model[ix] = '0;
    else bank_model[ix] = bank_model[ix] - v;
  endfunction

  function automatic int status_class(input logic [3:0] s);
    case (s)
      ST_OK:                 return CL_NORMAL;
      ST_BLOCK, ST_TMPBLOCK: return CL_BLOCKED;
      ST_TIMEOUT:            return CL_TIMEOUT;
      ST_IOERROR:            return CL_NETERR;
      ST_ERROR:              return CL_INTERR;
      ST_CLOSE:              return CL_PEERCLOSE;
      ST_ADMIN:              return CL_ADMIN;
      default:               return CL_OTHER;
    endcase
  endfunction

  function automatic void generic_event(input logic [3:0] code, input logic [63:0] v);
    if (code > EV_LAST) return;
    bump(int'(IX_ACCEPTED) + int'(code), v);
    if (code == EV_SESS_UP) bump(int'(IX_ACTIVE), v);
    else if (code == EV_SESS_DOWN) lower(int'(IX_ACTIVE), v);
  endfunction

  // Applies one word to the bank copy and returns the read_data it yields.
  function automatic logic [63:0] apply_stats_word(input stats_word_t w);
    logic [1:0]  pr;
    logic [2:0]  neg;
    int          sb;
    int          cmd_ix;
    int          cls;
    logic [63:0] rd;
    rd = '0;
    pr = (w.protocol_code > PR_UNKNOWN) ? PR_UNKNOWN : w.protocol_code;
    sb = int'(IX_SESS) + SESS_STRIDE * int'(pr);
    case (w.kind)
      K_GENERIC: generic_event(w.event_code, w.amount);
      K_NEG: begin
        neg = (w.negotiation_code > NEG_UNKNOWN) ? NEG_UNKNOWN : w.negotiation_code;
        bump(int'(IX_NEG) + int'(neg), w.amount);
        if (neg != NEG_SUCCESS) bump(int'(IX_NEGFAIL), w.amount);
      end
      K_REQ: begin
        if (w.command_byte >= CMD_CONNECT && w.command_byte <= CMD_UDP)
          cmd_ix = int'(w.command_byte - CMD_CONNECT);
        else
          cmd_ix = CMD_SLOT_UNKNOWN;
        cls = status_class(w.io_status);
        bump(int'(IX_REQ) + REQ_CLASSES * cmd_ix + cls, w.amount);
        if (cls != CL_NORMAL) bump(int'(IX_REQFAIL), w.amount);
      end
      K_START: begin
        generic_event(EV_SESS_UP, w.amount);
        bump(sb + int'(SK_STARTED), w.amount);
        bump(sb + int'(SK_ACTIVE), w.amount);
      end
      K_CLOSE: begin
        generic_event(EV_SESS_DOWN, w.amount);
        bump(sb + int'(SK_CLOSED), w.amount);
        lower(sb + int'(SK_ACTIVE), w.amount);
        bump(int'(IX_CLOSE) + status_class(w.io_status), w.amount);
        if (w.io_status == ST_TIMEOUT || w.io_status == ST_IOERROR ||
            w.io_status == ST_ERROR) begin
          bump(int'(IX_SESSERR), w.amount);
          bump(sb + int'(SK_ERRORS), w.amount);
        end
      end
      K_READ: if (w.read_index < NUM_COUNTERS) rd = bank_model[w.read_index];
      default: ;
    endcase
    return rd;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [63:0] random_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 64'($urandom_range(0, 1000));
    if (r < 72) return 64'd0;
    if (r < 90) return 64'($urandom_range(0, 1 << 20));
    if (r < 95) return 64'($urandom);
    if (r < 98) return {$urandom, $urandom};
    return CNT_MAX - 64'($urandom_range(0, 3));
  endfunction

  function automatic stats_word_t blank_word(input logic [2:0] kind);
    stats_word_t w;
    w = '0;
    w.kind = kind;
    return w;
  endfunction

  function automatic stats_word_t random_word();
    stats_word_t w;
    int r;
    w.event_code       = ($urandom_range(0, 7) == 0) ? 4'($urandom) :
                         4'($urandom_range(0, EV_LAST));
    w.negotiation_code = 3'($urandom);
    w.command_byte     = ($urandom_range(0, 2) == 0) ? 8'($urandom) :
                         8'($urandom_range(CMD_CONNECT, CMD_UDP));
    w.io_status        = 4'($urandom);
    w.protocol_code    = 2'($urandom);
    w.amount           = random_amount();
    w.read_index       = ($urandom_range(0, 5) == 0) ? 7'($urandom) :
                         7'($urandom_range(0, NUM_COUNTERS - 1));
    r = $urandom_range(0, 99);
    if (r < 25)      w.kind = K_GENERIC;
    else if (r < 35) w.kind = K_NEG;
    else if (r < 50) w.kind = K_REQ;
    else if (r < 60) w.kind = K_START;
    else if (r < 70) w.kind = K_CLOSE;
    else if (r < 96) w.kind = K_READ;
    else             w.kind = 3'($urandom_range(K_UNUSED_LO, K_UNUSED_HI));
    return w;
  endfunction

  function automatic stats_word_t read_word(input int ix);
    stats_word_t w;
    w = random_word();
    w.kind = K_READ;
    w.read_index = 7'(ix);
    return w;
  endfunction

  task automatic send_word(input stats_word_t w);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_kind             = w.kind;
    in_event_code       = w.event_code;
    in_negotiation_code = w.negotiation_code;
    in_command_byte     = w.command_byte;
    in_io_status        = w.io_status;
    in_protocol_code    = w.protocol_code;
    in_amount           = w.amount;
    in_read_index       = w.read_index;
    in_valid            = 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_read_data.push_back(apply_stats_word(w));
  endtask

  // negotiation, start, traffic, request and close on one protocol, then read back gauges
  task automatic session_lifecycle(output int n);
    stats_word_t w;
    logic [1:0]  pr;
    int          k;
    int          sb;
    pr = 2'($urandom);
    sb = int'(IX_SESS) + SESS_STRIDE * int'((pr > PR_UNKNOWN) ? PR_UNKNOWN : pr);
    w = random_word();
    w.kind = K_NEG;
    w.negotiation_code = ($urandom_range(0, 1) == 0) ? NEG_SUCCESS : 3'($urandom);
    send_word(w);
    w = random_word();
    w.kind = K_START;
    w.protocol_code = pr;
    w.amount = ($urandom_range(0, 7) == 0) ? random_amount() : 64'd1;
    send_word(w);
    k = $urandom_range(1, 3);
    repeat (k) begin
      w = random_word();
      w.kind = K_GENERIC;
      w.event_code = 4'($urandom_range(EV_CLIENT_RD, EV_LAST));
      send_word(w);
    end
    w = random_word();
    w.kind = K_REQ;
    send_word(w);
    w = random_word();
    w.kind = K_CLOSE;
    w.protocol_code = pr;
    w.amount = ($urandom_range(0, 7) == 0) ? random_amount() : 64'd1;
    send_word(w);
    send_word(read_word(sb + int'(SK_ACTIVE)));
    send_word(read_word(int'(IX_ACTIVE)));
    n = k + 6;
  endtask

  // ---------------- tests ----------------

  task automatic test_directed_corners();
    stats_word_t w;
    send_word(read_word(int'(IX_ACCEPTED)));
    send_word(read_word(NUM_COUNTERS - 1));
    send_word(read_word(int'(IDX_TOP)));
    w = blank_word(K_GENERIC); w.amount = CNT_MAX;               send_word(w);
    w = blank_word(K_GENERIC); w.amount = 64'd5;                 send_word(w);
    send_word(read_word(int'(IX_ACCEPTED)));
    w = blank_word(K_GENERIC); w.event_code = EV_SESS_UP;   w.amount = 64'd3;  send_word(w);
    w = blank_word(K_GENERIC); w.event_code = EV_SESS_DOWN; w.amount = 64'd10; send_word(w);
    send_word(read_word(int'(IX_ACTIVE)));
    w = blank_word(K_GENERIC); w.event_code = EV_CODE_TOP;  w.amount = 64'd7;  send_word(w);
    w = blank_word(K_GENERIC); w.event_code = EV_LAST;      w.amount = '0;     send_word(w);
    w = blank_word(K_NEG); w.negotiation_code = NEG_CODE_TOP; w.amount = 64'd1; send_word(w);
    w = blank_word(K_NEG); w.negotiation_code = NEG_SUCCESS;  w.amount = 64'd1; send_word(w);
    send_word(read_word(int'(IX_NEG) + int'(NEG_UNKNOWN)));
    w = blank_word(K_REQ); w.io_status = 4'hf; w.amount = 64'd2; send_word(w);
    w = blank_word(K_REQ); w.command_byte = CMD_CONNECT; w.io_status = ST_TMPBLOCK;
    w.amount = CNT_MAX; send_word(w);
    send_word(read_word(int'(IX_REQ) + REQ_CLASSES * CMD_SLOT_UNKNOWN + CL_OTHER));
    w = blank_word(K_START); w.protocol_code = PR_TOP; w.amount = 64'd2; send_word(w);
    w = blank_word(K_CLOSE); w.protocol_code = PR_TOP; w.io_status = ST_IOERROR;
    w.amount = 64'd5; send_word(w);
    send_word(read_word(int'(IX_SESS) + SESS_STRIDE * int'(PR_UNKNOWN) + int'(SK_ACTIVE)));
    w = blank_word(K_UNUSED_LO); w.amount = 64'd9; send_word(w);
    w = blank_word(K_UNUSED_HI); w.read_index = IX_ACCEPTED; send_word(w);
    send_word(read_word(int'(IX_CLOSE) + CL_NETERR));
    send_word(read_word(int'(IX_SESSERR)));
    send_word(read_word(int'(IX_REQFAIL)));
  endtask

  task automatic test_random_traffic(input int target);
    int sent;
    int n;
    int r;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        session_lifecycle(n);
        sent += n;
      end else if (r < 7) begin
        send_word(random_word());
        sent++;
      end else begin
        send_word(read_word($urandom_range(0, NUM_COUNTERS - 1)));
        sent++;
      end
    end
  endtask

  // receiver holds off while words keep coming, so the core backs up
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    repeat (20) send_word(random_word());
    while (hold_request) @(posedge clk);
  endtask

  task automatic test_drain_no_idle();
    quiet = 1'b1;
    test_random_traffic(100);
  endtask

  // ---------------- receiver side ----------------

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    logic [63:0] want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_read_data.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got %h", $time,
                 out_read_data);
        fail_count++;
      end else begin
        want = pending_read_data.pop_front();
        if (out_read_data !== want) begin
          $display("%0t: read_data mismatch: expected %h, got %h", $time, want,
                   out_read_data);
          fail_count++;
        end
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_kind             = '0;
    in_event_code       = '0;
    in_negotiation_code = '0;
    in_command_byte     = '0;
    in_io_status        = '0;
    in_protocol_code    = '0;
    in_amount           = '0;
    in_read_index       = '0;
    for (int i = 0; i < NUM_COUNTERS; i++) bank_model[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_corners();
    test_random_traffic(1150);
    test_output_backpressure();
    test_drain_no_idle();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_read_data.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
